FILE: rtl/mwst_pkg.sv
package mwst_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int INDEX_BITS     = 16;
  localparam int CFG_BITS       = 9;
  localparam int START_BITS     = 16;
  localparam int SUM_OUT_BITS   = 24;
  localparam int DEF_MAX_WINDOW = 256;

  localparam logic signed [SUM_OUT_BITS-1:0] SUM_OUT_MAX = {1'b0, {(SUM_OUT_BITS-1){1'b1}}};
  localparam logic signed [SUM_OUT_BITS-1:0] SUM_OUT_MIN = {1'b1, {(SUM_OUT_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } mwst_in_t;

  typedef struct packed {
    logic [START_BITS-1:0]          start_index;
    logic signed [SUM_OUT_BITS-1:0] best_sum;
  } mwst_out_t;

  typedef struct packed {
    logic                  valid;
    logic                  full;
    logic                  last;
    logic [INDEX_BITS-1:0] cand;
  } mwst_stage_t;

endpackage

FILE: rtl/max_window_sum_tracker.sv
// max_window_sum_tracker
// finds the fixed-length window of a sample sequence with the largest sum
// cfg channel (cfg_valid/cfg_ready/cfg_data): window length, always ready,
//   latched at the first sample of each sequence; 0 acts as 1, values above
//   MAX_WINDOW act as MAX_WINDOW
// in channel (in_valid/in_ready/in_data): one signed sample per transaction,
//   last marks the end of a sequence
// out channel (out_valid/out_ready/out_data): one transaction per sequence
//   with the start index and the best sum (saturated to 24 bits)
// throughput: one sample per cycle with in_ready high, set by the single
//   add/subtract of the running sum and the one-step cell chain shift
// result: the last sample is registered into the stage, and out_valid rises
//   when that stage entry is consumed by the best-sum tracker
// stall: samples keep flowing while a result waits; in_ready drops only when
//   a second result is ready and the first has not been taken
// reset: window length 1, sequence state and any pending result cleared
module max_window_sum_tracker #(
  parameter int MAX_WINDOW = mwst_pkg::DEF_MAX_WINDOW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mwst_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mwst_pkg::mwst_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mwst_pkg::mwst_out_t           out_data
);
  import mwst_pkg::*;

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + LEN_W + 1;

  mwst_stage_t             stage;
  logic signed [SUM_W-1:0] stage_sum;
  logic                    take;

  mwst_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .LEN_W      (LEN_W),
    .SUM_W      (SUM_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .take      (take),
    .stage     (stage),
    .stage_sum (stage_sum)
  );

  mwst_best #(
    .SUM_W (SUM_W)
  ) u_best (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .stage_sum (stage_sum),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/mwst_cell.sv
module mwst_cell #(
  parameter int LEN_W    = 9,
  parameter int CELL_IDX = 0
) (
  input  logic                                  clk,
  input  logic                                  shift,
  input  logic [LEN_W-1:0]                      len_m1,
  input  logic signed [mwst_pkg::SAMPLE_BITS-1:0] new_sample,
  input  logic signed [mwst_pkg::SAMPLE_BITS-1:0] next_sample,
  output logic signed [mwst_pkg::SAMPLE_BITS-1:0] q
);

  // new sample enters at the cell of the window's far end, the rest move toward cell 0
  always_ff @(posedge clk) begin
    if (shift) begin
      if (len_m1 == LEN_W'(CELL_IDX)) begin
        q <= new_sample;
      end else begin
        q <= next_sample;
      end
    end
  end

endmodule

FILE: rtl/mwst_window.sv
module mwst_window #(
  parameter int MAX_WINDOW = mwst_pkg::DEF_MAX_WINDOW,
  parameter int LEN_W      = $clog2(MAX_WINDOW + 1),
  parameter int SUM_W      = mwst_pkg::SAMPLE_BITS + $clog2(MAX_WINDOW + 1) + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mwst_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mwst_pkg::mwst_in_t            in_data,
  input  logic                          take,
  output mwst_pkg::mwst_stage_t         stage,
  output logic signed [SUM_W-1:0]       stage_sum
);
  import mwst_pkg::*;

  logic [CFG_BITS-1:0]         win_len;
  logic [LEN_W-1:0]            active_len;
  logic [LEN_W-1:0]            clamp_len;
  logic [LEN_W-1:0]            cur_len;
  logic [LEN_W-1:0]            len_m1;
  logic [LEN_W-1:0]            fill;
  logic                        seq_start;
  logic [INDEX_BITS-1:0]       pos;
  logic [INDEX_BITS:0]         pos_p1;
  logic [INDEX_BITS:0]         len_ext;
  logic [INDEX_BITS-1:0]       cand;
  logic signed [SUM_W-1:0]     run_sum;
  logic signed [SUM_W-1:0]     run_sum_next;
  logic signed [SUM_W-1:0]     x_ext;
  logic signed [SUM_W-1:0]     drop;
  logic                        full;
  logic                        accept;
  logic signed [SAMPLE_BITS-1:0] cell_q [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cell_nxt [MAX_WINDOW];

  assign cfg_ready = 1'b1;
  assign in_ready  = take;
  assign accept    = in_valid && in_ready;

  always_comb begin
    if (win_len == '0) begin
      clamp_len = LEN_W'(1);
    end else if (int'(win_len) > MAX_WINDOW) begin
      clamp_len = LEN_W'(MAX_WINDOW);
    end else begin
      clamp_len = LEN_W'(win_len);
    end
  end

  assign cur_len = seq_start ? clamp_len : active_len;
  assign len_m1  = cur_len - LEN_W'(1);
  assign full    = (fill == cur_len);

  genvar k;
  generate
    for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
      if (k == MAX_WINDOW - 1) begin : g_end
        assign cell_nxt[k] = '0;
      end else begin : g_mid
        assign cell_nxt[k] = cell_q[k+1];
      end
      mwst_cell #(
        .LEN_W    (LEN_W),
        .CELL_IDX (k)
      ) u_cell (
        .clk         (clk),
        .shift       (accept),
        .len_m1      (len_m1),
        .new_sample  (in_data.sample),
        .next_sample (cell_nxt[k]),
        .q           (cell_q[k])
      );
    end
  endgenerate

  assign x_ext = SUM_W'(in_data.sample);
  assign drop  = SUM_W'(cell_q[0]);

  always_comb begin
    if (full) begin
      run_sum_next = run_sum - drop + x_ext;
    end else begin
      run_sum_next = run_sum + x_ext;
    end
  end

  assign pos_p1  = {1'b0, pos} + (INDEX_BITS+1)'(1);
  assign len_ext = (INDEX_BITS+1)'(cur_len);
  assign cand    = (pos_p1 >= len_ext) ? INDEX_BITS'(pos_p1 - len_ext) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len    <= CFG_BITS'(1);
      active_len <= LEN_W'(1);
      seq_start  <= 1'b1;
      fill       <= '0;
      pos        <= '0;
      run_sum    <= '0;
      stage      <= '0;
    end else begin
      if (cfg_valid) begin
        win_len <= cfg_data;
      end
      if (take) begin
        stage.valid <= in_valid;
      end
      if (accept) begin
        active_len <= cur_len;
        stage.full <= full;
        stage.last <= in_data.last;
        stage.cand <= cand;
        if (in_data.last) begin
          seq_start <= 1'b1;
          fill      <= '0;
          pos       <= '0;
          run_sum   <= '0;
        end else begin
          seq_start <= 1'b0;
          run_sum   <= run_sum_next;
          if (!full) begin
            fill <= fill + LEN_W'(1);
          end
          if (pos != '1) begin
            pos <= pos + INDEX_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_sum <= run_sum_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.last |=> seq_start && fill == '0 && pos == '0 && run_sum == '0)
    else $error("sequence state not cleared after last sample");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    !seq_start |-> fill <= active_len)
    else $error("fill count beyond window length");

endmodule

FILE: rtl/mwst_best.sv
module mwst_best #(
  parameter int SUM_W = mwst_pkg::SAMPLE_BITS + 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mwst_pkg::mwst_stage_t   stage,
  input  logic signed [SUM_W-1:0] stage_sum,
  output logic                    take,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mwst_pkg::mwst_out_t     out_data
);
  import mwst_pkg::*;

  localparam int CMP_W = (SUM_W > SUM_OUT_BITS) ? SUM_W : SUM_OUT_BITS;

  logic signed [SUM_W-1:0]  best_value;
  logic signed [SUM_W-1:0]  best_value_next;
  logic [INDEX_BITS-1:0]    best_start;
  logic [INDEX_BITS-1:0]    best_start_next;
  logic signed [CMP_W-1:0]  best_ext;
  logic signed [SUM_OUT_BITS-1:0] best_sat;
  logic                     consume;

  assign take    = !stage.valid || !stage.last || !out_valid || out_ready;
  assign consume = stage.valid && take;

  always_comb begin
    best_value_next = best_value;
    best_start_next = best_start;
    if (!stage.full) begin
      best_value_next = stage_sum;
    end else if (stage_sum >= best_value) begin
      best_value_next = stage_sum;
      best_start_next = stage.cand;
    end
  end

  assign best_ext = CMP_W'(best_value_next);

  always_comb begin
    if (best_ext > CMP_W'(SUM_OUT_MAX)) begin
      best_sat = SUM_OUT_MAX;
    end else if (best_ext < CMP_W'(SUM_OUT_MIN)) begin
      best_sat = SUM_OUT_MIN;
    end else begin
      best_sat = SUM_OUT_BITS'(best_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_value <= '0;
      best_start <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (consume) begin
        if (stage.last) begin
          best_value <= '0;
          best_start <= '0;
        end else begin
          best_value <= best_value_next;
          best_start <= best_start_next;
        end
      end
      if (consume && stage.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && stage.last) begin
      out_data.start_index <= START_BITS'(best_start_next);
      out_data.best_sum    <= best_sat;
    end
  end

  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    consume && stage.last |=> out_valid)
    else $error("no result after last sample");

  a_best_cleared: assert property (@(posedge clk) disable iff (rst)
    consume && stage.last |=> best_value == '0 && best_start == '0)
    else $error("best tracking not cleared after result");

endmodule
